// File: src/vfct_pkg.sv
// shared types and constants for the view frustum culling tests block
`timescale 1ns / 1ps

package vfct_pkg;

    localparam int PLANE_REGS = 6;
    localparam int NEAR_IDX   = 5;
    localparam int REG_W      = 64;
    localparam int MASK_W     = 6;
    localparam int ADDR_W     = 6;
    localparam int IDX_LSB    = 3;
    localparam int IDX_W      = 3;

    localparam logic [MASK_W-1:0] FULL_MASK = 6'h3f;

    typedef enum logic [1:0] {
        MODE_BOX      = 2'd0,
        MODE_SPHERE   = 2'd1,
        MODE_NEAR_PT  = 2'd2,
        MODE_NEAR_BOX = 2'd3
    } mode_t;

    typedef logic [PLANE_REGS-1:0][REG_W-1:0] plane_bank_t;

endpackage

// File: src/view_frustum_cull_tests_top.sv
// top level: stream pipeline with input register, plane lanes and result register
// a beat accepted into the input register moves on to the result register and the master side
// throughput: one beat per cycle while the master side does not stall, all six plane lanes evaluate in parallel
// a stalled result blocks the input only once the input register also holds a beat
// reset clears all plane registers to zero and empties both pipeline registers
`timescale 1ns / 1ps

module view_frustum_cull_tests_top
    import vfct_pkg::*;
#(
    parameter int PLANE_COUNT    = 6,
    parameter int COORD_BITS     = 20,
    parameter int COEF_FRAC_BITS = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [REG_W-1:0]     pwdata,
    output logic [REG_W-1:0]     prdata,
    output logic                 pready,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, radius, distance, zero pad
    input  logic [((8*COORD_BITS-1+7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // visible, plane_mask, zero pad
    output logic [7:0]           m_axis_tdata
);

    localparam int C = COORD_BITS;

    plane_bank_t planes;

    logic                in_valid_reg;
    mode_t               in_mode_reg;
    logic signed [C-1:0] in_ax_reg, in_ay_reg, in_az_reg;
    logic signed [C-1:0] in_bx_reg, in_by_reg, in_bz_reg;
    logic [C-2:0]        in_rad_reg;
    logic signed [C-1:0] in_dist_reg;

    logic                out_valid_reg;
    logic                out_vis_reg;
    logic [MASK_W-1:0]   out_mask_reg;

    logic                adv;
    logic                s_take;
    logic [PLANE_REGS-1:0] lane_pass;
    logic [MASK_W-1:0]   cull_mask;
    logic                vis_next;
    logic [MASK_W-1:0]   mask_next;

    vfct_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes)
    );

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || adv;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (adv)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_mode_reg <= mode_t'(s_axis_tuser);
            in_ax_reg   <= s_axis_tdata[0*C +: C];
            in_ay_reg   <= s_axis_tdata[1*C +: C];
            in_az_reg   <= s_axis_tdata[2*C +: C];
            in_bx_reg   <= s_axis_tdata[3*C +: C];
            in_by_reg   <= s_axis_tdata[4*C +: C];
            in_bz_reg   <= s_axis_tdata[5*C +: C];
            in_rad_reg  <= s_axis_tdata[6*C +: C-1];
            in_dist_reg <= s_axis_tdata[7*C-1 +: C];
        end
        if (in_valid_reg && adv)
        begin
            out_vis_reg  <= vis_next;
            out_mask_reg <= mask_next;
        end
    end

    for (genvar g = 0; g < PLANE_REGS; g++)
    begin : g_lane
        vfct_lane #(
            .COORD_BITS     (COORD_BITS),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .plane    (planes[g]),
            .mode     (in_mode_reg),
            .ax       (in_ax_reg),
            .ay       (in_ay_reg),
            .az       (in_az_reg),
            .bx       (in_bx_reg),
            .by       (in_by_reg),
            .bz       (in_bz_reg),
            .radius   (in_rad_reg),
            .distance (in_dist_reg),
            .pass     (lane_pass[g])
        );
    end

    // planes past the configured count are not tested and read as passing
    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            cull_mask[i] = (i < PLANE_COUNT) ? lane_pass[i] : FULL_MASK[i];
        end
    end

    always_comb
    begin
        case (in_mode_reg)
            MODE_BOX, MODE_SPHERE:
            begin
                mask_next = cull_mask;
                vis_next  = &cull_mask;
            end
            default:
            begin
                mask_next = '0;
                vis_next  = lane_pass[NEAR_IDX];
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_mask_reg, out_vis_reg};

`ifndef SYNTHESIS
    a_near_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && adv && (in_mode_reg == MODE_NEAR_PT || in_mode_reg == MODE_NEAR_BOX)
        |=> out_mask_reg == '0)
        else $error("near mode result carries a plane mask");

    a_cull_vis_mask: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && adv && (in_mode_reg == MODE_BOX || in_mode_reg == MODE_SPHERE)
        |=> out_vis_reg == (&out_mask_reg))
        else $error("visible flag disagrees with plane mask");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !adv |-> !s_axis_tready)
        else $error("beat taken while both pipeline registers are full");

    a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without a beat in the input register");
`endif

endmodule

// File: src/vfct_regs.sv
// plane coefficient registers behind the apb configuration port
`timescale 1ns / 1ps

module vfct_regs
    import vfct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [REG_W-1:0]  pwdata,
    output logic [REG_W-1:0]  prdata,
    output logic              pready,
    output plane_bank_t       planes
);

    plane_bank_t      plane_reg;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[IDX_LSB +: IDX_W];
    assign wr_en  = psel && penable && pwrite && pready;
    assign planes = plane_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
        end
        else if (wr_en && ({1'b0, idx} < (IDX_W + 1)'(PLANE_REGS)))
        begin
            plane_reg[idx] <= pwdata;
        end
    end

    always_comb
    begin
        prdata = '0;
        if ({1'b0, idx} < (IDX_W + 1)'(PLANE_REGS))
        begin
            prdata = plane_reg[idx];
        end
    end

endmodule

// File: src/vfct_lane.sv
// one plane evaluated against the current beat: operand select, products, sum, sign test
`timescale 1ns / 1ps

module vfct_lane
    import vfct_pkg::*;
#(
    parameter int COORD_BITS     = 20,
    parameter int COEF_FRAC_BITS = 12
)
(
    input  logic [REG_W-1:0]              plane,
    input  mode_t                         mode,
    input  logic signed [COORD_BITS-1:0]  ax,
    input  logic signed [COORD_BITS-1:0]  ay,
    input  logic signed [COORD_BITS-1:0]  az,
    input  logic signed [COORD_BITS-1:0]  bx,
    input  logic signed [COORD_BITS-1:0]  by,
    input  logic signed [COORD_BITS-1:0]  bz,
    input  logic [COORD_BITS-2:0]         radius,
    input  logic signed [COORD_BITS-1:0]  distance,
    output logic                          pass
);

    localparam int CW  = COEF_FRAC_BITS + 2;
    localparam int DW  = REG_W - 3 * CW;
    localparam int XW  = COORD_BITS + 1;
    localparam int PW  = CW + XW;
    localparam int MW  = (DW > COORD_BITS) ? DW : COORD_BITS;
    localparam int DTW = MW + 3;
    localparam int SW  = ((PW > DTW + COEF_FRAC_BITS) ? PW : DTW + COEF_FRAC_BITS) + 3;

    logic signed [CW-1:0]  coef_a, coef_b, coef_c;
    logic signed [DW-1:0]  coef_d;
    logic signed [XW-1:0]  ax_e, ay_e, az_e, bx_e, by_e, bz_e;
    logic signed [XW-1:0]  op_x, op_y, op_z;
    logic signed [DTW-1:0] d_e, rad_e, dist_e, dterm;
    logic signed [PW-1:0]  prod_x, prod_y, prod_z;
    logic signed [SW-1:0]  sum;

    assign coef_a = plane[CW-1:0];
    assign coef_b = plane[2*CW-1:CW];
    assign coef_c = plane[3*CW-1:2*CW];
    assign coef_d = plane[REG_W-1:3*CW];

    assign ax_e = XW'(ax);
    assign ay_e = XW'(ay);
    assign az_e = XW'(az);
    assign bx_e = XW'(bx);
    assign by_e = XW'(by);
    assign bz_e = XW'(bz);

    assign d_e    = DTW'(coef_d);
    assign rad_e  = DTW'(signed'({1'b0, radius}));
    assign dist_e = DTW'(distance);

    always_comb
    begin
        case (mode)
            MODE_BOX:
            begin
                // corner farthest along the plane normal
                op_x  = ((coef_a >= 0) == (bx >= ax)) ? bx_e : ax_e;
                op_y  = ((coef_b >= 0) == (by >= ay)) ? by_e : ay_e;
                op_z  = ((coef_c >= 0) == (bz >= az)) ? bz_e : az_e;
                dterm = d_e;
            end
            MODE_SPHERE:
            begin
                op_x  = ax_e;
                op_y  = ay_e;
                op_z  = az_e;
                dterm = d_e + rad_e;
            end
            MODE_NEAR_PT:
            begin
                op_x  = ax_e;
                op_y  = ay_e;
                op_z  = az_e;
                dterm = d_e;
            end
            MODE_NEAR_BOX:
            begin
                // doubled center against doubled threshold
                op_x  = ax_e + bx_e;
                op_y  = ay_e + by_e;
                op_z  = az_e + bz_e;
                dterm = (d_e <<< 1) - (dist_e <<< 1);
            end
            default:
            begin
                op_x  = ax_e;
                op_y  = ay_e;
                op_z  = az_e;
                dterm = d_e;
            end
        endcase
    end

    assign prod_x = PW'(coef_a) * op_x;
    assign prod_y = PW'(coef_b) * op_y;
    assign prod_z = PW'(coef_c) * op_z;

    assign sum = SW'(prod_x) + SW'(prod_y) + SW'(prod_z)
               + (SW'(dterm) <<< COEF_FRAC_BITS);

    always_comb
    begin
        case (mode)
            MODE_SPHERE, MODE_NEAR_BOX:
            begin
                pass = (sum > 0);
            end
            default:
            begin
                pass = (sum >= 0);
            end
        endcase
    end

endmodule
